@@ design/dbs_pkg.sv @@
package dbs_pkg;

  // Width of a signed Q8.8 sample position. The base position reaches about
  // 1050 pixels and the offset adds up to 128 more, so 21 bits hold every case.
  localparam int POS_W = 21;

  // Width of the plane entries and of all Q8.8 payload fields.
  localparam int PIX_W = 16;

  // Width of the configuration write data.
  localparam int CFG_W = 7;

  // Width of a load index.
  localparam int IDX_W = 12;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_PLANE_HEIGHT  = 3'd0,
    REG_PLANE_WIDTH   = 3'd1,
    REG_PAD_ROWS      = 3'd2,
    REG_PAD_COLS      = 3'd3,
    REG_STRIDE_ROWS   = 3'd4,
    REG_STRIDE_COLS   = 3'd5,
    REG_DILATION_ROWS = 3'd6,
    REG_DILATION_COLS = 3'd7
  } dbs_reg_e;

  // Command codes.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Configuration register file.
  typedef struct packed {
    logic [6:0] plane_height;
    logic [6:0] plane_width;
    logic [3:0] pad_rows;
    logic [3:0] pad_cols;
    logic [3:0] stride_rows;
    logic [3:0] stride_cols;
    logic [3:0] dilation_rows;
    logic [3:0] dilation_cols;
  } dbs_cfg_t;

  // Per-request control and payload that follows the pixel fetch.
  typedef struct packed {
    logic              sample;
    logic              outside;
    logic [3:0]        nb_ok;
    logic [7:0]        lh;
    logic [7:0]        lw;
    logic signed [15:0] mask;
  } dbs_meta_t;

endpackage

@@ design/dbs_ram.sv @@
module dbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // One registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/dbs_addr.sv @@
module dbs_addr #(
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_KERNEL = 8,
  parameter int AW         = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  dbs_pkg::dbs_cfg_t        cfg_i,
  input  logic                     valid_i,
  input  logic                     command_i,
  input  logic [11:0]              pixel_index_i,
  input  logic signed [15:0]       pixel_value_i,
  input  logic [5:0]               out_row_i,
  input  logic [5:0]               out_col_i,
  input  logic [2:0]               tap_row_i,
  input  logic [2:0]               tap_col_i,
  input  logic signed [15:0]       offset_row_i,
  input  logic signed [15:0]       offset_col_i,
  input  logic signed [15:0]       mask_value_i,
  output logic                     valid_o,
  output dbs_pkg::dbs_meta_t       meta_o,
  output logic                     we_o,
  output logic [AW-1:0]            waddr_o,
  output logic [15:0]              wdata_o,
  output logic [AW-1:0]            raddr_o [4]
);

  import dbs_pkg::*;

  localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
  localparam int HCW   = $clog2(MAX_HEIGHT + 1);
  localparam int WCW   = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT) + 1;
  localparam int CW    = $clog2(MAX_WIDTH) + 1;
  localparam int RXW   = RW + 1;
  localparam int CXW   = CW + 1;
  localparam int SAW   = AW + 2;
  // Load indexes wrap only when the plane holds fewer entries than an index reaches.
  localparam bit WRAP  = (DEPTH < (1 << IDX_W));
  localparam int MOD_K = WRAP ? DEPTH : 1;
  localparam int RECIP = (1 << 24) / MOD_K + 1;
  localparam int QP_W  = IDX_W + 24;
  localparam int REM_W = IDX_W + 1;

  // Clamped plane size.
  logic [HCW-1:0] hc;
  logic [WCW-1:0] wc;

  always_comb begin
    if (cfg_i.plane_height == 7'd0) begin
      hc = HCW'(1);
    end else if (int'(cfg_i.plane_height) > MAX_HEIGHT) begin
      hc = HCW'(MAX_HEIGHT);
    end else begin
      hc = HCW'(cfg_i.plane_height);
    end
    if (cfg_i.plane_width == 7'd0) begin
      wc = WCW'(1);
    end else if (int'(cfg_i.plane_width) > MAX_WIDTH) begin
      wc = WCW'(MAX_WIDTH);
    end else begin
      wc = WCW'(cfg_i.plane_width);
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: base position, Q8.8 sample position and load index quotient.
  // ---------------------------------------------------------------
  logic [2:0]              tap_r, tap_c;
  logic [9:0]              row_prod, col_prod;
  logic [6:0]              tapr_prod, tapc_prod;
  logic [POS_W-1:0]        y_base, x_base;
  logic signed [POS_W-1:0] y_d, x_d;
  logic [QP_W-1:0]         qprod;
  logic [IDX_W-1:0]        q_d;

  always_comb begin
    tap_r     = (int'(tap_row_i) > MAX_KERNEL - 1) ? 3'(MAX_KERNEL - 1) : tap_row_i;
    tap_c     = (int'(tap_col_i) > MAX_KERNEL - 1) ? 3'(MAX_KERNEL - 1) : tap_col_i;
    row_prod  = 10'(out_row_i) * 10'(cfg_i.stride_rows);
    col_prod  = 10'(out_col_i) * 10'(cfg_i.stride_cols);
    tapr_prod = 7'(tap_r) * 7'(cfg_i.dilation_rows);
    tapc_prod = 7'(tap_c) * 7'(cfg_i.dilation_cols);
    y_base    = POS_W'(row_prod) + POS_W'(tapr_prod) - POS_W'(cfg_i.pad_rows);
    x_base    = POS_W'(col_prod) + POS_W'(tapc_prod) - POS_W'(cfg_i.pad_cols);
    y_d       = $signed(y_base << 8) + POS_W'(offset_row_i);
    x_d       = $signed(x_base << 8) + POS_W'(offset_col_i);
    // Quotient of the load index by the plane depth through a reciprocal.
    qprod     = QP_W'(pixel_index_i) * QP_W'(RECIP);
    q_d       = qprod[QP_W-1:24];
  end

  logic                    s1_valid_q;
  logic                    s1_cmd_q;
  logic signed [POS_W-1:0] s1_y_q, s1_x_q;
  logic signed [15:0]      s1_mask_q;
  logic [IDX_W-1:0]        s1_idx_q, s1_quo_q;
  logic [15:0]             s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_cmd_q  <= command_i;
      s1_y_q    <= y_d;
      s1_x_q    <= x_d;
      s1_mask_q <= mask_value_i;
      s1_idx_q  <= pixel_index_i;
      s1_quo_q  <= q_d;
      s1_pix_q  <= pixel_value_i;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: outside test, top-left neighbor, fractions, load address.
  // ---------------------------------------------------------------
  logic signed [POS_W-1:0] yp, xp, h256, w256;
  logic [POS_W-9:0]        r_top, c_top;
  logic signed [RW-1:0]    r0_d;
  logic signed [CW-1:0]    c0_d;
  logic signed [RXW-1:0]   r1, hcs;
  logic signed [CXW-1:0]   c1, wcs;
  logic                    outside_d;
  logic [3:0]              nb_ok_d;
  logic                    top_ok, bot_ok, lft_ok, rgt_ok;
  logic [REM_W-1:0]        rem;
  logic [AW-1:0]           waddr_d;

  always_comb begin
    h256      = $signed(POS_W'({hc, 8'h00}));
    w256      = $signed(POS_W'({wc, 8'h00}));
    outside_d = (s1_y_q <= POS_W'(-256)) || (s1_y_q >= h256)
             || (s1_x_q <= POS_W'(-256)) || (s1_x_q >= w256);
    yp        = s1_y_q + POS_W'(256);
    xp        = s1_x_q + POS_W'(256);
    r_top     = yp[POS_W-1:8];
    c_top     = xp[POS_W-1:8];
    r0_d      = RW'(r_top - 1'b1);
    c0_d      = CW'(c_top - 1'b1);
    r1        = RXW'(r0_d) + RXW'(1);
    c1        = CXW'(c0_d) + CXW'(1);
    hcs       = RXW'($signed({1'b0, hc}));
    wcs       = CXW'($signed({1'b0, wc}));
    top_ok    = !r0_d[RW-1];
    bot_ok    = r1 < hcs;
    lft_ok    = !c0_d[CW-1];
    rgt_ok    = c1 < wcs;
    nb_ok_d   = {bot_ok & rgt_ok, bot_ok & lft_ok, top_ok & rgt_ok, top_ok & lft_ok};
    rem       = REM_W'(s1_idx_q) - REM_W'(s1_quo_q * REM_W'(MOD_K));
    waddr_d   = WRAP ? AW'(rem) : AW'(s1_idx_q);
  end

  logic                 s2_valid_q;
  logic                 s2_cmd_q;
  logic                 s2_outside_q;
  logic signed [RW-1:0] s2_r0_q;
  logic signed [CW-1:0] s2_c0_q;
  logic [7:0]           s2_lh_q, s2_lw_q;
  logic [3:0]           s2_nb_ok_q;
  logic signed [15:0]   s2_mask_q;
  logic [AW-1:0]        s2_waddr_q;
  logic [15:0]          s2_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_cmd_q     <= s1_cmd_q;
      s2_outside_q <= outside_d;
      s2_r0_q      <= r0_d;
      s2_c0_q      <= c0_d;
      s2_lh_q      <= yp[7:0];
      s2_lw_q      <= xp[7:0];
      s2_nb_ok_q   <= nb_ok_d;
      s2_mask_q    <= s1_mask_q;
      s2_waddr_q   <= waddr_d;
      s2_pix_q     <= s1_pix_q;
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: linear addresses of the four neighbors.
  // ---------------------------------------------------------------
  logic signed [SAW-1:0] wsa, rw, a00, a10;

  always_comb begin
    wsa = SAW'($signed({1'b0, wc}));
    rw  = SAW'(s2_r0_q) * wsa;
    a00 = rw + SAW'(s2_c0_q);
    a10 = a00 + wsa;
  end

  logic               s3_valid_q;
  dbs_meta_t          s3_meta_q;
  logic               s3_cmd_q;
  logic [AW-1:0]      s3_waddr_q;
  logic [15:0]        s3_pix_q;
  logic [AW-1:0]      s3_addr_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_cmd_q          <= s2_cmd_q;
      s3_meta_q.sample  <= s2_valid_q && (s2_cmd_q == CMD_SAMPLE);
      s3_meta_q.outside <= s2_outside_q;
      s3_meta_q.nb_ok   <= s2_nb_ok_q;
      s3_meta_q.lh      <= s2_lh_q;
      s3_meta_q.lw      <= s2_lw_q;
      s3_meta_q.mask    <= s2_mask_q;
      s3_waddr_q        <= s2_waddr_q;
      s3_pix_q          <= s2_pix_q;
      s3_addr_q[0]      <= AW'(a00);
      s3_addr_q[1]      <= AW'(a00 + SAW'(1));
      s3_addr_q[2]      <= AW'(a10);
      s3_addr_q[3]      <= AW'(a10 + SAW'(1));
    end
  end

  // Loads write the plane from the same stage that issues the reads, so
  // requests see the plane in arrival order.
  assign valid_o = s3_valid_q;
  assign meta_o  = s3_meta_q;
  assign we_o    = en_i && s3_valid_q && (s3_cmd_q == CMD_LOAD);
  assign waddr_o = s3_waddr_q;
  assign wdata_o = s3_pix_q;
  assign raddr_o = s3_addr_q;

endmodule

@@ design/dbs_interp.sv @@
module dbs_interp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  dbs_pkg::dbs_meta_t meta_i,
  input  logic [15:0]        rdata_i [4],
  output logic               out_valid_o,
  output logic signed [15:0] sample_value_o,
  output logic               fully_outside_o
);

  import dbs_pkg::*;

  localparam int WT_W   = 17;
  localparam int PROD_W = 33;
  localparam int MUL_W  = 49;
  localparam int Q_W    = MUL_W - 24;

  // Stage t1 lines up with the registered plane reads.
  logic      t1_valid_q;
  dbs_meta_t t1_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_valid_q <= 1'b0;
    end else if (en_i) begin
      t1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_meta_q <= meta_i;
    end
  end

  // Corner weights and zeroing of neighbors outside the plane.
  logic [8:0]         hh, hw, lh9, lw9;
  logic [WT_W-1:0]    wt_d [4];
  logic signed [15:0] pix_d [4];

  always_comb begin
    lh9      = 9'(t1_meta_q.lh);
    lw9      = 9'(t1_meta_q.lw);
    hh       = 9'd256 - lh9;
    hw       = 9'd256 - lw9;
    wt_d[0]  = WT_W'(hh) * WT_W'(hw);
    wt_d[1]  = WT_W'(hh) * WT_W'(lw9);
    wt_d[2]  = WT_W'(lh9) * WT_W'(hw);
    wt_d[3]  = WT_W'(lh9) * WT_W'(lw9);
    for (int i = 0; i < 4; i++) begin
      pix_d[i] = t1_meta_q.nb_ok[i] ? $signed(rdata_i[i]) : 16'sd0;
    end
  end

  logic               t2_valid_q;
  dbs_meta_t          t2_meta_q;
  logic [WT_W-1:0]    t2_wt_q [4];
  logic signed [15:0] t2_pix_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t2_valid_q <= 1'b0;
    end else if (en_i) begin
      t2_valid_q <= t1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t2_meta_q <= t1_meta_q;
      t2_wt_q   <= wt_d;
      t2_pix_q  <= pix_d;
    end
  end

  // Weighted corner products.
  logic signed [PROD_W-1:0] prod_d [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_d[i] = PROD_W'($signed({1'b0, t2_wt_q[i]})) * PROD_W'(t2_pix_q[i]);
    end
  end

  logic                     t3_valid_q;
  dbs_meta_t                t3_meta_q;
  logic signed [PROD_W-1:0] t3_prod_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t3_valid_q <= 1'b0;
    end else if (en_i) begin
      t3_valid_q <= t2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t3_meta_q <= t2_meta_q;
      t3_prod_q <= prod_d;
    end
  end

  // Sum of the four corners, exact in Q.24.
  logic                     t4_valid_q;
  dbs_meta_t                t4_meta_q;
  logic signed [PROD_W-1:0] t4_acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t4_valid_q <= 1'b0;
    end else if (en_i) begin
      t4_valid_q <= t3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t4_meta_q <= t3_meta_q;
      t4_acc_q  <= (t3_prod_q[0] + t3_prod_q[1]) + (t3_prod_q[2] + t3_prod_q[3]);
    end
  end

  // Modulation by the mask, exact in Q.32.
  logic                    t5_valid_q;
  dbs_meta_t               t5_meta_q;
  logic signed [MUL_W-1:0] t5_mul_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t5_valid_q <= 1'b0;
    end else if (en_i) begin
      t5_valid_q <= t4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t5_meta_q <= t4_meta_q;
      t5_mul_q  <= MUL_W'(t4_acc_q) * MUL_W'(t4_meta_q.mask);
    end
  end

  // Round half up to Q8.8 and saturate. The arithmetic shift is a floor,
  // which matches both signs of the product.
  logic signed [MUL_W-1:0] rnd;
  logic signed [Q_W-1:0]   quo;
  logic signed [15:0]      sat_d;

  always_comb begin
    rnd = t5_mul_q + MUL_W'(1 << 23);
    quo = Q_W'(rnd >>> 24);
    if (quo > Q_W'(32767)) begin
      sat_d = 16'sh7fff;
    end else if (quo < Q_W'(-32768)) begin
      sat_d = -16'sh8000;
    end else begin
      sat_d = 16'(quo);
    end
  end

  // Output register: only sample requests produce a result.
  logic               out_valid_q;
  logic signed [15:0] out_value_q;
  logic               out_outside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= t5_valid_q && t5_meta_q.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_value_q   <= t5_meta_q.outside ? 16'sd0 : sat_d;
      out_outside_q <= t5_meta_q.outside;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_value_o  = out_value_q;
  assign fully_outside_o = out_outside_q;

endmodule

@@ design/deformable_bilinear_sampler.sv @@
// Deformable bilinear sampler. The block keeps one feature plane of signed
// Q8.8 pixels, written by load requests (row times plane width plus column),
// and answers each sample request with mask times the bilinear interpolation
// at base position plus learned offset, rounded and saturated to Q8.8, or zero
// with fully_outside set when the position lies wholly off the plane. Loads
// give no result. A request of either kind is taken in every cycle unless a
// stalled result is held at the output. A result passes through the address
// pipeline (position, neighbor, linear address), the registered plane read,
// and the weight, product, sum, mask and rounding stages. Four copies of the
// plane serve the four neighbor reads at once. Stalling the output holds the
// whole pipeline in place. Configuration writes are taken at any time and
// must only be made while the block is idle.
module deformable_bilinear_sampler #(
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_KERNEL = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [6:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [11:0]        pixel_index_i,
  input  logic signed [15:0] pixel_value_i,
  input  logic [5:0]         out_row_i,
  input  logic [5:0]         out_col_i,
  input  logic [2:0]         tap_row_i,
  input  logic [2:0]         tap_col_i,
  input  logic signed [15:0] offset_row_i,
  input  logic signed [15:0] offset_col_i,
  input  logic signed [15:0] mask_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] sample_value_o,
  output logic               fully_outside_o
);

  import dbs_pkg::*;

  localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers.
  dbs_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.plane_height  <= 7'd64;
      cfg_q.plane_width   <= 7'd64;
      cfg_q.pad_rows      <= 4'd0;
      cfg_q.pad_cols      <= 4'd0;
      cfg_q.stride_rows   <= 4'd1;
      cfg_q.stride_cols   <= 4'd1;
      cfg_q.dilation_rows <= 4'd1;
      cfg_q.dilation_cols <= 4'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (dbs_reg_e'(cfg_index_i))
        REG_PLANE_HEIGHT:  cfg_q.plane_height  <= cfg_data_i;
        REG_PLANE_WIDTH:   cfg_q.plane_width   <= cfg_data_i;
        REG_PAD_ROWS:      cfg_q.pad_rows      <= cfg_data_i[3:0];
        REG_PAD_COLS:      cfg_q.pad_cols      <= cfg_data_i[3:0];
        REG_STRIDE_ROWS:   cfg_q.stride_rows   <= cfg_data_i[3:0];
        REG_STRIDE_COLS:   cfg_q.stride_cols   <= cfg_data_i[3:0];
        REG_DILATION_ROWS: cfg_q.dilation_rows <= cfg_data_i[3:0];
        REG_DILATION_COLS: cfg_q.dilation_cols <= cfg_data_i[3:0];
      endcase
    end
  end

  // The pipeline advances unless a finished result is being held.
  logic en;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Address front end.
  logic          fe_valid;
  dbs_meta_t     fe_meta;
  logic          fe_we;
  logic [AW-1:0] fe_waddr;
  logic [15:0]   fe_wdata;
  logic [AW-1:0] fe_raddr [4];
  logic [15:0]   rdata [4];

  dbs_addr #(
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL),
    .AW         (AW)
  ) u_addr (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .cfg_i         (cfg_q),
    .valid_i       (in_valid_i),
    .command_i     (command_i),
    .pixel_index_i (pixel_index_i),
    .pixel_value_i (pixel_value_i),
    .out_row_i     (out_row_i),
    .out_col_i     (out_col_i),
    .tap_row_i     (tap_row_i),
    .tap_col_i     (tap_col_i),
    .offset_row_i  (offset_row_i),
    .offset_col_i  (offset_col_i),
    .mask_value_i  (mask_value_i),
    .valid_o       (fe_valid),
    .meta_o        (fe_meta),
    .we_o          (fe_we),
    .waddr_o       (fe_waddr),
    .wdata_o       (fe_wdata),
    .raddr_o       (fe_raddr)
  );

  // One copy of the plane per neighbor, all written together.
  for (genvar g = 0; g < 4; g++) begin : g_plane
    dbs_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (fe_we),
      .waddr_i (fe_waddr),
      .wdata_i (fe_wdata),
      .re_i    (en),
      .raddr_i (fe_raddr[g]),
      .rdata_o (rdata[g])
    );
  end

  // Interpolation back end.
  dbs_interp u_interp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .valid_i         (fe_valid),
    .meta_i          (fe_meta),
    .rdata_i         (rdata),
    .out_valid_o     (out_valid_o),
    .sample_value_o  (sample_value_o),
    .fully_outside_o (fully_outside_o)
  );

endmodule

@@ tb/deformable_bilinear_sampler_test.sv @@
`timescale 1ns / 1ps

module deformable_bilinear_sampler_test;
  import dbs_pkg::*;

  // One request as it enters the block.
  typedef struct {
    logic               cmd;
    logic [11:0]        idx;
    logic signed [15:0] pixel;
    logic [5:0]         out_row;
    logic [5:0]         out_col;
    logic [2:0]         tap_row;
    logic [2:0]         tap_col;
    logic signed [15:0] offset_row;
    logic signed [15:0] offset_col;
    logic signed [15:0] mask;
  } sampler_req_t;

  // One expected sample.
  typedef struct {
    logic signed [15:0] value;
    logic               outside;
  } sample_t;

  // Keeps its own copy of the plane and registers and predicts each sample.
  class sampler_scoreboard;
    int                 regs[8];
    logic signed [15:0] plane[4096];
    sample_t            expected_samples[$];
    int                 mismatches;
    int                 samples_seen;

    function new();
      regs = '{64, 64, 0, 0, 1, 1, 1, 1};
      mismatches = 0;
      samples_seen = 0;
    endfunction

    function void set_reg(dbs_reg_e index, int data);
      regs[index] = (index <= REG_PLANE_WIDTH) ? (data & 'h7f) : (data & 'hf);
    endfunction

    function longint pixel_at(int r, int c, int h, int w);
      if (r < 0 || c < 0 || r >= h || c >= w) return 0;
      return longint'(plane[(r * w + c) % 4096]);
    endfunction

    // Note an accepted request: loads update the plane, samples are predicted.
    function void note_request(sampler_req_t r);
      int      h, w, y, x, r0, c0, lh, lw;
      longint  acc, prod, q;
      sample_t e;
      if (r.cmd == CMD_LOAD) begin
        plane[r.idx] = r.pixel;
        return;
      end
      h = regs[REG_PLANE_HEIGHT] < 1 ? 1 : (regs[REG_PLANE_HEIGHT] > 64 ? 64 : regs[REG_PLANE_HEIGHT]);
      w = regs[REG_PLANE_WIDTH] < 1 ? 1 : (regs[REG_PLANE_WIDTH] > 64 ? 64 : regs[REG_PLANE_WIDTH]);
      y = (int'(r.out_row) * regs[REG_STRIDE_ROWS] - regs[REG_PAD_ROWS]
          + int'(r.tap_row) * regs[REG_DILATION_ROWS]) * 256 + int'(r.offset_row);
      x = (int'(r.out_col) * regs[REG_STRIDE_COLS] - regs[REG_PAD_COLS]
          + int'(r.tap_col) * regs[REG_DILATION_COLS]) * 256 + int'(r.offset_col);
      if (y <= -256 || y >= h * 256 || x <= -256 || x >= w * 256) begin
        e.value = '0;
        e.outside = 1'b1;
      end else begin
        r0 = ((y + 256) >>> 8) - 1;
        c0 = ((x + 256) >>> 8) - 1;
        lh = (y + 256) & 255;
        lw = (x + 256) & 255;
        acc = longint'((256 - lh) * (256 - lw)) * pixel_at(r0, c0, h, w)
            + longint'((256 - lh) * lw) * pixel_at(r0, c0 + 1, h, w)
            + longint'(lh * (256 - lw)) * pixel_at(r0 + 1, c0, h, w)
            + longint'(lh * lw) * pixel_at(r0 + 1, c0 + 1, h, w);
        // Rounding to nearest with ties upward is a floor after adding half.
        prod = acc * longint'(r.mask) + (longint'(1) <<< 23);
        q = prod >>> 24;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        e.value = q[15:0];
        e.outside = 1'b0;
      end
      expected_samples.push_back(e);
    endfunction

    // Compare one delivered sample with the oldest prediction.
    function void check_sample(logic signed [15:0] value, logic outside);
      sample_t e;
      samples_seen++;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected sample: value %0d outside %0b", value, outside);
        return;
      end
      e = expected_samples.pop_front();
      if (value !== e.value || outside !== e.outside) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Sample mismatch: expected value %0d outside %0b, got value %0d outside %0b",
                   e.value, e.outside, value, outside);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [6:0]         cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               command_i;
  logic [11:0]        pixel_index_i;
  logic signed [15:0] pixel_value_i;
  logic [5:0]         out_row_i;
  logic [5:0]         out_col_i;
  logic [2:0]         tap_row_i;
  logic [2:0]         tap_col_i;
  logic signed [15:0] offset_row_i;
  logic signed [15:0] offset_col_i;
  logic signed [15:0] mask_value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] sample_value_o;
  logic               fully_outside_o;

  sampler_scoreboard sb = new();
  bit                quiet_phase = 1'b0;
  bit                hold_request = 1'b0;
  int                cycle_count = 0;
  int                phase_count = 0;

  deformable_bilinear_sampler u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("FAIL");
      $finish;
    end
  end

  // Outputs are stable at the falling edge; a sample taken there is accepted
  // at the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_sample(sample_value_o, fully_outside_o);
  end

  // Receiver back-pressure: random bursts, one long hold when asked, none at the end.
  initial begin
    int n;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        n = 0;
        while (n < 300) begin
          @(posedge clk_i);
          n++;
        end
        hold_request = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one request and wait for the edge where it is accepted.
  task automatic send_request(sampler_req_t r);
    bit taken;
    in_valid_i    <= 1'b1;
    command_i     <= r.cmd;
    pixel_index_i <= r.idx;
    pixel_value_i <= r.pixel;
    out_row_i     <= r.out_row;
    out_col_i     <= r.out_col;
    tap_row_i     <= r.tap_row;
    tap_col_i     <= r.tap_col;
    offset_row_i  <= r.offset_row;
    offset_col_i  <= r.offset_col;
    mask_value_i  <= r.mask;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
    end
    @(posedge clk_i);
    sb.note_request(r);
    // Sender gaps, away from the quiet phase.
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // Write one register; valid drops for a cycle before the next write.
  task automatic write_reg(dbs_reg_e index, int data);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data[6:0];
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = cfg_ready_o;
    end
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.set_reg(index, data);
    @(posedge clk_i);
  endtask

  // Wait until every sample is back, then let trailing loads drain.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (sb.expected_samples.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_all(int h, int w, int pr, int pc, int sr, int sc, int dr, int dc);
    write_reg(REG_PLANE_HEIGHT, h);
    write_reg(REG_PLANE_WIDTH, w);
    write_reg(REG_PAD_ROWS, pr);
    write_reg(REG_PAD_COLS, pc);
    write_reg(REG_STRIDE_ROWS, sr);
    write_reg(REG_STRIDE_COLS, sc);
    write_reg(REG_DILATION_ROWS, dr);
    write_reg(REG_DILATION_COLS, dc);
  endtask

  function automatic sampler_req_t make_load(int idx, int value);
    sampler_req_t r;
    r = '{default: '0};
    r.cmd = CMD_LOAD;
    r.idx = idx[11:0];
    r.pixel = value[15:0];
    r.out_row = 6'($urandom);
    r.out_col = 6'($urandom);
    r.tap_row = 3'($urandom);
    r.tap_col = 3'($urandom);
    r.offset_row = 16'($urandom);
    r.offset_col = 16'($urandom);
    r.mask = 16'($urandom);
    return r;
  endfunction

  function automatic sampler_req_t make_sample(int orow, int ocol, int trow, int tcol,
                                               int offr, int offc, int mask);
    sampler_req_t r;
    r.cmd = CMD_SAMPLE;
    r.idx = 12'($urandom);
    r.pixel = 16'($urandom);
    r.out_row = orow[5:0];
    r.out_col = ocol[5:0];
    r.tap_row = trow[2:0];
    r.tap_col = tcol[2:0];
    r.offset_row = offr[15:0];
    r.offset_col = offc[15:0];
    r.mask = mask[15:0];
    return r;
  endfunction

  // Random request shaped to land mostly on or near the plane.
  function automatic sampler_req_t random_request();
    int offr, offc, mask, orow, ocol;
    if ($urandom_range(0, 4) == 0) return make_load($urandom, $urandom);
    orow = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
    ocol = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
    offr = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 2047) - 1024;
    offc = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 2047) - 1024;
    mask = ($urandom_range(0, 2) == 0) ? 256 : $urandom;
    return make_sample(orow, ocol, $urandom, $urandom, offr, offc, mask);
  endfunction

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    command_i     <= CMD_LOAD;
    pixel_index_i <= '0;
    pixel_value_i <= '0;
    out_row_i     <= '0;
    out_col_i     <= '0;
    tap_row_i     <= '0;
    tap_col_i     <= '0;
    offset_row_i  <= '0;
    offset_col_i  <= '0;
    mask_value_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the first 1024 entries; every setting below keeps height times
    // width within them, so no sample reads an unwritten entry.
    quiet_phase = 1'b1;
    for (int i = 0; i < 1024; i++) send_request(make_load(i, $urandom));
    quiet_phase = 1'b0;

    // Directed part on a 16 by 64 plane: extreme pixels, plane edges and
    // corners, offsets at both ends, masks at both ends, largest taps.
    drain();
    write_all(16, 64, 0, 0, 1, 1, 1, 1);
    send_request(make_load(0, 32767));
    send_request(make_load(1, -32768));
    send_request(make_load(64, 32767));
    send_request(make_load(65, 32767));
    send_request(make_load(4095, -32768));
    send_request(make_sample(0, 0, 0, 0, 0, 0, 256));
    send_request(make_sample(0, 0, 0, 0, 128, 128, 32767));
    send_request(make_sample(0, 0, 0, 0, -255, -255, 256));
    send_request(make_sample(0, 0, 0, 0, -256, 0, 256));
    send_request(make_sample(0, 0, 0, 0, 0, -256, 256));
    send_request(make_sample(15, 63, 0, 0, 255, 255, 256));
    send_request(make_sample(15, 0, 0, 0, 256, 0, 256));
    send_request(make_sample(0, 63, 0, 0, 0, 256, 256));
    send_request(make_sample(8, 56, 7, 7, 0, 0, -32768));
    send_request(make_sample(0, 0, 0, 0, 32767, 0, 256));
    send_request(make_sample(40, 40, 0, 0, -32768, -32768, 256));
    send_request(make_sample(0, 0, 0, 0, 1, 0, -32768));
    send_request(make_sample(0, 0, 0, 0, 0, 1, 32767));
    send_request(make_sample(5, 5, 3, 3, 77, -77, 0));
    send_request(make_sample(63, 63, 7, 7, 0, 0, 256));

    // Phases of settings, extremes and out-of-range values among them.
    for (int p = 0; p < 7; p++) begin
      drain();
      case (p)
        0: write_all(1, 1, 15, 15, 8, 8, 8, 8);
        1: write_all(16, 64, 0, 0, 1, 1, 1, 1);
        2: write_all(0, 127, 3, 9, 0, 0, 0, 0);
        3: write_all(2, 64, 1, 0, 2, 1, 1, 3);
        default: write_all($urandom_range(1, 16), $urandom_range(1, 64),
                           $urandom_range(0, 15), $urandom_range(0, 15),
                           $urandom_range(1, 8), $urandom_range(1, 8),
                           $urandom_range(1, 8), $urandom_range(1, 8));
      endcase
      phase_count++;
      quiet_phase = (p == 6);
      if (p == 1) hold_request = 1'b1;
      for (int i = 0; i < 65; i++) send_request(random_request());
    end

    drain();
    $display("Covered %0d samples across %0d register settings, with full-range offsets,",
             sb.samples_seen, phase_count + 1);
    $display("masks, plane edges, saturation and a long output hold.");
    if (sb.mismatches == 0 && sb.expected_samples.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
